FILE: rtl/c_like_tokenizer_unit_macros.svh
// Assertion helpers used by the checker of the tokeniser.
`ifndef C_LIKE_TOKENIZER_UNIT_MACROS_SVH
`define C_LIKE_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CTOK_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokeniser check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CTOK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokeniser check failed");

`endif

FILE: rtl/ctok_pkg.sv
`default_nettype none

package ctok_pkg;

  localparam int OFFSET_BITS     = 16;
  localparam int KEYWORD_CHARS   = 6;
  localparam int KW_BITS         = 8 * KEYWORD_CHARS;
  localparam int LEN_BITS        = 16;
  localparam int NUM_BITS        = 31;
  localparam int KIND_BITS       = 5;
  localparam int NUM_KEYWORDS    = 5;
  localparam int RES_QUEUE_DEPTH = 4;
  localparam int RES_PTR_BITS    = $clog2(RES_QUEUE_DEPTH);
  localparam int RES_CNT_BITS    = $clog2(RES_QUEUE_DEPTH + 1);

  typedef logic [KIND_BITS-1:0] kind_t;

  localparam kind_t TOK_EOF     = 5'd0;
  localparam kind_t TOK_NUMBER  = 5'd1;
  localparam kind_t TOK_IDENT   = 5'd2;
  localparam kind_t TOK_IF      = 5'd3;
  localparam kind_t TOK_ELSE    = 5'd4;
  localparam kind_t TOK_FOR     = 5'd5;
  localparam kind_t TOK_WHILE   = 5'd6;
  localparam kind_t TOK_RETURN  = 5'd7;
  localparam kind_t TOK_LPAREN  = 5'd8;
  localparam kind_t TOK_RPAREN  = 5'd9;
  localparam kind_t TOK_LBRACE  = 5'd10;
  localparam kind_t TOK_RBRACE  = 5'd11;
  localparam kind_t TOK_SEMI    = 5'd12;
  localparam kind_t TOK_COMMA   = 5'd13;
  localparam kind_t TOK_PLUS    = 5'd14;
  localparam kind_t TOK_MINUS   = 5'd15;
  localparam kind_t TOK_STAR    = 5'd16;
  localparam kind_t TOK_SLASH   = 5'd17;
  localparam kind_t TOK_PERCENT = 5'd18;
  localparam kind_t TOK_ASSIGN  = 5'd19;
  localparam kind_t TOK_EQ      = 5'd20;
  localparam kind_t TOK_NE      = 5'd21;
  localparam kind_t TOK_LT      = 5'd22;
  localparam kind_t TOK_LE      = 5'd23;
  localparam kind_t TOK_GT      = 5'd24;
  localparam kind_t TOK_GE      = 5'd25;
  localparam kind_t TOK_UNKNOWN = 5'd26;

  localparam logic [NUM_BITS-1:0] NUM_MAX = '1;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [KW_BITS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
    KW_BITS'(64'h6966), KW_BITS'(64'h656C7365), KW_BITS'(64'h666F72),
    KW_BITS'(64'h7768696C65), KW_BITS'(64'h72657475726E)
  };
  localparam logic [LEN_BITS-1:0] KW_LEN [NUM_KEYWORDS] = '{
    LEN_BITS'(2), LEN_BITS'(4), LEN_BITS'(3), LEN_BITS'(5), LEN_BITS'(6)
  };
  localparam kind_t KW_KIND [NUM_KEYWORDS] = '{
    TOK_IF, TOK_ELSE, TOK_FOR, TOK_WHILE, TOK_RETURN
  };

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_NUM, MODE_IDENT, MODE_SLASH, MODE_EQ,
    MODE_BANG, MODE_LT, MODE_GT, MODE_COMMENT
  } scan_mode_t;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
  } in_t;

  typedef struct packed {
    kind_t                  token_kind;
    logic [NUM_BITS-1:0]    number_value;
    logic                   number_overflow;
    logic [15:0]            token_start;
    logic [LEN_BITS-1:0]    token_length;
    logic [7:0]             unknown_byte;
    logic                   last_of_run;
  } out_t;

  typedef struct packed {
    scan_mode_t             mode;
    logic [OFFSET_BITS-1:0] pos;
    logic [OFFSET_BITS-1:0] start;
    logic [LEN_BITS-1:0]    len;
    logic [NUM_BITS-1:0]    acc;
    logic                   sat;
    logic [KW_BITS-1:0]     kwbuf;
  } scan_state_t;

  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } scan_res_t;

  localparam scan_state_t STATE_RESET = '{mode: MODE_IDLE, default: '0};

  function automatic out_t make_res(input kind_t kind, input logic [NUM_BITS-1:0] val,
                                    input logic ovf, input logic [OFFSET_BITS-1:0] start,
                                    input logic [LEN_BITS-1:0] len, input logic [7:0] ub);
    out_t r;
    r.token_kind      = kind;
    r.number_value    = val;
    r.number_overflow = ovf;
    r.token_start     = start[15:0];
    r.token_length    = len;
    r.unknown_byte    = ub;
    r.last_of_run     = 1'b0;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {" ", [8'd9:8'd13]};
  endfunction

  // Kind of a byte that is a token on its own, or TOK_EOF if it is not one.
  function automatic kind_t symbol_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      "(":     k = TOK_LPAREN;
      ")":     k = TOK_RPAREN;
      "{":     k = TOK_LBRACE;
      "}":     k = TOK_RBRACE;
      ";":     k = TOK_SEMI;
      ",":     k = TOK_COMMA;
      "+":     k = TOK_PLUS;
      "-":     k = TOK_MINUS;
      "*":     k = TOK_STAR;
      "%":     k = TOK_PERCENT;
      default: k = TOK_EOF;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/c_like_tokenizer_unit.sv
`default_nettype none

// Streaming lexer for a small C-like language. One source byte (or an end-of-source
// beat) is taken per cycle whenever the queue holds two results or fewer; its
// tokens are written to a four-entry result queue and, if it was empty, the first
// of them is offered on the out channel in the next cycle. A byte that both closes
// a token and starts a one-byte token gives two results. When the output drains
// one result per cycle, the queue soaks up the extra result of the first such byte;
// each later one holds input off until a result is taken. Spaces, comments and
// bytes that extend an open token give no result. After the end-of-file token the
// scanner and its byte offset are back in their reset state.
module c_like_tokenizer_unit (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  wire ctok_pkg::in_t in_data,
  output logic           out_valid,
  input  wire            out_ready,
  output ctok_pkg::out_t out_data
);

  ctok_pkg::scan_state_t                st_r;
  ctok_pkg::scan_state_t                st_nxt;
  ctok_pkg::scan_res_t                  scan_res;
  ctok_pkg::out_t                       queue_r [ctok_pkg::RES_QUEUE_DEPTH];
  logic [ctok_pkg::RES_PTR_BITS-1:0]    wr_ptr_r;
  logic [ctok_pkg::RES_PTR_BITS-1:0]    wr_ptr_nxt;
  logic [ctok_pkg::RES_PTR_BITS-1:0]    rd_ptr_r;
  logic [ctok_pkg::RES_PTR_BITS-1:0]    rd_ptr_nxt;
  logic [ctok_pkg::RES_CNT_BITS-1:0]    count_r;
  logic [ctok_pkg::RES_CNT_BITS-1:0]    count_nxt;
  logic                                 push;
  logic                                 pop;
  logic [1:0]                           n_push;

  ctok_scan u_scan (
    .st     (st_r),
    .item   (in_data),
    .st_nxt (st_nxt),
    .res    (scan_res)
  );

  // Room for the two results that any one beat can produce.
  assign in_ready  = count_r <= ctok_pkg::RES_CNT_BITS'(ctok_pkg::RES_QUEUE_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_data  = queue_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign n_push    = push ? scan_res.count : 2'd0;

  assign wr_ptr_nxt = wr_ptr_r + ctok_pkg::RES_PTR_BITS'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + ctok_pkg::RES_PTR_BITS'(pop);
  assign count_nxt  = count_r + ctok_pkg::RES_CNT_BITS'(n_push)
                    - ctok_pkg::RES_CNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ctok_pkg::STATE_RESET;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        st_r <= st_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && scan_res.count != 2'd0) begin
      queue_r[wr_ptr_r] <= scan_res.first;
    end
    if (push && scan_res.count == 2'd2) begin
      queue_r[wr_ptr_r + 1'b1] <= scan_res.second;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ctok_scan.sv
`default_nettype none

module ctok_scan (
  input  wire ctok_pkg::scan_state_t st,
  input  wire ctok_pkg::in_t         item,
  output ctok_pkg::scan_state_t      st_nxt,
  output ctok_pkg::scan_res_t        res
);

  logic [7:0]                        c;
  logic                              eof;
  logic                              taken;
  logic                              fin_v;
  ctok_pkg::out_t                    fin;
  ctok_pkg::kind_t                   ident_kind;
  ctok_pkg::kind_t                   op2_kind;
  ctok_pkg::kind_t                   sym;
  logic                              a_v;
  logic                              b_v;
  ctok_pkg::out_t                    a;
  ctok_pkg::out_t                    b;
  logic [ctok_pkg::NUM_BITS+3:0]     prod;
  logic [ctok_pkg::LEN_BITS-1:0]     len_inc;
  logic [ctok_pkg::OFFSET_BITS-1:0]  pos_inc;

  assign c   = item.ch;
  assign eof = item.op || (c == 8'd0);

  // value * 10 + digit, four bits wider than the accumulator so overflow shows
  assign prod = ({4'b0, st.acc} << 3) + ({4'b0, st.acc} << 1)
              + (ctok_pkg::NUM_BITS + 4)'(c[3:0]);
  assign len_inc = (st.len == '1) ? st.len : st.len + 1'b1;
  assign pos_inc = st.pos + 1'b1;
  assign sym     = ctok_pkg::symbol_kind(c);

  always_comb begin
    ident_kind = ctok_pkg::TOK_IDENT;
    for (int k = 0; k < ctok_pkg::NUM_KEYWORDS; k++) begin
      if (st.len == ctok_pkg::KW_LEN[k] && st.kwbuf == ctok_pkg::KW_TEXT[k]) begin
        ident_kind = ctok_pkg::KW_KIND[k];
      end
    end
  end

  always_comb begin
    case (st.mode)
      ctok_pkg::MODE_EQ:   op2_kind = ctok_pkg::TOK_EQ;
      ctok_pkg::MODE_BANG: op2_kind = ctok_pkg::TOK_NE;
      ctok_pkg::MODE_LT:   op2_kind = ctok_pkg::TOK_LE;
      default:             op2_kind = ctok_pkg::TOK_GE;
    endcase
  end

  // The token that is still open when a byte cannot extend it.
  always_comb begin
    fin_v = 1'b1;
    fin   = ctok_pkg::make_res(ctok_pkg::TOK_EOF, '0, 1'b0, st.start, 16'd1, 8'd0);
    case (st.mode)
      ctok_pkg::MODE_NUM:
        fin = ctok_pkg::make_res(ctok_pkg::TOK_NUMBER, st.acc, st.sat, st.start, st.len, 8'd0);
      ctok_pkg::MODE_IDENT:
        fin = ctok_pkg::make_res(ident_kind, '0, 1'b0, st.start, st.len, 8'd0);
      ctok_pkg::MODE_SLASH: fin.token_kind = ctok_pkg::TOK_SLASH;
      ctok_pkg::MODE_EQ:    fin.token_kind = ctok_pkg::TOK_ASSIGN;
      ctok_pkg::MODE_LT:    fin.token_kind = ctok_pkg::TOK_LT;
      ctok_pkg::MODE_GT:    fin.token_kind = ctok_pkg::TOK_GT;
      ctok_pkg::MODE_BANG: begin
        fin.token_kind   = ctok_pkg::TOK_UNKNOWN;
        fin.unknown_byte = "!";
      end
      default: fin_v = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt = st;
    taken  = 1'b0;
    a_v    = 1'b0;
    a      = fin;
    b_v    = 1'b0;
    b      = ctok_pkg::make_res(ctok_pkg::TOK_EOF, '0, 1'b0, st.pos, '0, 8'd0);
    if (eof) begin
      a_v    = fin_v;
      b_v    = 1'b1;
      st_nxt = ctok_pkg::STATE_RESET;
    end else begin
      case (st.mode)
        ctok_pkg::MODE_NUM: begin
          if (ctok_pkg::is_digit(c)) begin
            taken = 1'b1;
            st_nxt.len = len_inc;
            if (prod > {4'b0, ctok_pkg::NUM_MAX}) begin
              st_nxt.acc = ctok_pkg::NUM_MAX;
              st_nxt.sat = 1'b1;
            end else begin
              st_nxt.acc = prod[ctok_pkg::NUM_BITS-1:0];
            end
          end
        end
        ctok_pkg::MODE_IDENT: begin
          if (ctok_pkg::is_alpha(c) || ctok_pkg::is_digit(c) || c == "_") begin
            taken = 1'b1;
            st_nxt.len = len_inc;
            if (st.len < ctok_pkg::LEN_BITS'(ctok_pkg::KEYWORD_CHARS)) begin
              st_nxt.kwbuf = {st.kwbuf[ctok_pkg::KW_BITS-9:0], c};
            end
          end
        end
        ctok_pkg::MODE_SLASH: begin
          if (c == "/") begin
            taken       = 1'b1;
            st_nxt.mode = ctok_pkg::MODE_COMMENT;
          end
        end
        ctok_pkg::MODE_EQ, ctok_pkg::MODE_BANG, ctok_pkg::MODE_LT, ctok_pkg::MODE_GT: begin
          if (c == "=") begin
            taken       = 1'b1;
            a_v         = 1'b1;
            a           = ctok_pkg::make_res(op2_kind, '0, 1'b0, st.start, 16'd2, 8'd0);
            st_nxt.mode = ctok_pkg::MODE_IDLE;
          end
        end
        ctok_pkg::MODE_COMMENT: begin
          taken = 1'b1;
          if (c == ctok_pkg::CH_NEWLINE) begin
            st_nxt.mode = ctok_pkg::MODE_IDLE;
          end
        end
        default: taken = 1'b0;
      endcase

      // The byte could not extend the open token: close it and scan the byte afresh.
      if (!taken) begin
        a_v          = fin_v;
        st_nxt.mode  = ctok_pkg::MODE_IDLE;
        st_nxt.start = st.pos;
        st_nxt.len   = 16'd1;
        if (ctok_pkg::is_space(c)) begin
          st_nxt.len = '0;
        end else if (ctok_pkg::is_digit(c)) begin
          st_nxt.mode = ctok_pkg::MODE_NUM;
          st_nxt.acc  = ctok_pkg::NUM_BITS'(c[3:0]);
          st_nxt.sat  = 1'b0;
        end else if (ctok_pkg::is_alpha(c) || c == "_") begin
          st_nxt.mode  = ctok_pkg::MODE_IDENT;
          st_nxt.kwbuf = ctok_pkg::KW_BITS'(c);
        end else if (c == "/") begin
          st_nxt.mode = ctok_pkg::MODE_SLASH;
        end else if (c == "=") begin
          st_nxt.mode = ctok_pkg::MODE_EQ;
        end else if (c == "!") begin
          st_nxt.mode = ctok_pkg::MODE_BANG;
        end else if (c == "<") begin
          st_nxt.mode = ctok_pkg::MODE_LT;
        end else if (c == ">") begin
          st_nxt.mode = ctok_pkg::MODE_GT;
        end else if (sym != ctok_pkg::TOK_EOF) begin
          b_v = 1'b1;
          b   = ctok_pkg::make_res(sym, '0, 1'b0, st.pos, 16'd1, 8'd0);
        end else begin
          b_v = 1'b1;
          b   = ctok_pkg::make_res(ctok_pkg::TOK_UNKNOWN, '0, 1'b0, st.pos, 16'd1, c);
        end
      end
      st_nxt.pos = pos_inc;
    end
  end

  always_comb begin
    res.count  = {1'b0, a_v} + {1'b0, b_v};
    res.first  = a_v ? a : b;
    res.second = b;
    res.first.last_of_run  = !(a_v && b_v);
    res.second.last_of_run = 1'b1;
  end

endmodule

`default_nettype wire

FILE: rtl/ctok_checker.sv
`default_nettype none

`include "c_like_tokenizer_unit_macros.svh"

module ctok_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire ctok_pkg::in_t  in_data,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire ctok_pkg::out_t out_data
);

  // A result offered and not taken stays on offer, unchanged.
  `CTOK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // An end-of-source beat always yields at least the end-of-file token.
  `CTOK_ASSERT_NEXT(a_eof_yields, in_valid && in_ready && in_data.op, out_valid)

  // Nothing follows the end-of-file token within the same beat.
  `CTOK_ASSERT_NOW(a_eof_last, out_valid && out_data.token_kind == ctok_pkg::TOK_EOF,
                   out_data.last_of_run)

  // Only number tokens carry a value or an overflow flag.
  `CTOK_ASSERT_NOW(a_value_only_num,
                   out_valid && out_data.token_kind != ctok_pkg::TOK_NUMBER,
                   out_data.number_value == '0 && !out_data.number_overflow)

endmodule

bind c_like_tokenizer_unit ctok_checker u_ctok_checker (.*);

`default_nettype wire

FILE: bench/c_like_tokenizer_unit_test.sv
`default_nettype none

module c_like_tokenizer_unit_test;
  import ctok_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 284;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
    logic       typed;
    out_t       want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  row_t script [25];
  row_t feed [$];
  out_t tokens_due [$];
  int   fed;
  int   errors = 0;
  int   stall_cycles = 0;
  int   send_idle = 0;
  int   recv_idle = 0;

  // Scanner state mirrored on the bench side.
  scan_mode_t       lex_mode;
  logic [15:0]      lex_pos;
  logic [15:0]      lex_start;
  logic [15:0]      lex_len;
  logic [30:0]      lex_acc;
  logic             lex_sat;
  logic [KW_BITS-1:0] lex_kw;
  out_t             lex_out [2];
  int               lex_n;

  c_like_tokenizer_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic digit_ch(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter_ch(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic blank_ch(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  task automatic lex_clear();
    lex_mode  = MODE_IDLE;
    lex_pos   = '0;
    lex_start = '0;
    lex_len   = '0;
    lex_acc   = '0;
    lex_sat   = 1'b0;
    lex_kw    = '0;
  endtask

  task automatic put_tok(input kind_t kind, input logic [30:0] val, input logic ovf,
                         input logic [15:0] start, input logic [15:0] len,
                         input logic [7:0] ub);
    if (lex_n < 2) begin
      lex_out[lex_n] = '{kind, val, ovf, start, len, ub, 1'b0};
      lex_n++;
    end
  endtask

  // Emits whatever token is still open and drops back to idle.
  task automatic close_token();
    kind_t kind;
    case (lex_mode)
      MODE_NUM: put_tok(TOK_NUMBER, lex_acc, lex_sat, lex_start, lex_len, 8'd0);
      MODE_IDENT: begin
        kind = TOK_IDENT;
        for (int k = 0; k < NUM_KEYWORDS; k++)
          if (lex_len == KW_LEN[k] && lex_kw == KW_TEXT[k]) kind = KW_KIND[k];
        put_tok(kind, '0, 1'b0, lex_start, lex_len, 8'd0);
      end
      MODE_SLASH: put_tok(TOK_SLASH, '0, 1'b0, lex_start, 16'd1, 8'd0);
      MODE_EQ:    put_tok(TOK_ASSIGN, '0, 1'b0, lex_start, 16'd1, 8'd0);
      MODE_BANG:  put_tok(TOK_UNKNOWN, '0, 1'b0, lex_start, 16'd1, "!");
      MODE_LT:    put_tok(TOK_LT, '0, 1'b0, lex_start, 16'd1, 8'd0);
      MODE_GT:    put_tok(TOK_GT, '0, 1'b0, lex_start, 16'd1, 8'd0);
      default: ;
    endcase
    lex_mode = MODE_IDLE;
  endtask

  task automatic open_token(input logic [7:0] c, input logic [15:0] here);
    lex_start = here;
    lex_len   = 16'd1;
    if (blank_ch(c)) begin
      lex_len = 16'd0;
    end else if (digit_ch(c)) begin
      lex_mode = MODE_NUM;
      lex_acc  = 31'(c - 8'd48);
      lex_sat  = 1'b0;
    end else if (letter_ch(c)) begin
      lex_mode = MODE_IDENT;
      lex_kw   = KW_BITS'(c);
    end else begin
      case (c)
        "/": lex_mode = MODE_SLASH;
        "=": lex_mode = MODE_EQ;
        "!": lex_mode = MODE_BANG;
        "<": lex_mode = MODE_LT;
        ">": lex_mode = MODE_GT;
        "(": put_tok(TOK_LPAREN, '0, 1'b0, here, 16'd1, 8'd0);
        ")": put_tok(TOK_RPAREN, '0, 1'b0, here, 16'd1, 8'd0);
        "{": put_tok(TOK_LBRACE, '0, 1'b0, here, 16'd1, 8'd0);
        "}": put_tok(TOK_RBRACE, '0, 1'b0, here, 16'd1, 8'd0);
        ";": put_tok(TOK_SEMI, '0, 1'b0, here, 16'd1, 8'd0);
        ",": put_tok(TOK_COMMA, '0, 1'b0, here, 16'd1, 8'd0);
        "+": put_tok(TOK_PLUS, '0, 1'b0, here, 16'd1, 8'd0);
        "-": put_tok(TOK_MINUS, '0, 1'b0, here, 16'd1, 8'd0);
        "*": put_tok(TOK_STAR, '0, 1'b0, here, 16'd1, 8'd0);
        "%": put_tok(TOK_PERCENT, '0, 1'b0, here, 16'd1, 8'd0);
        default: put_tok(TOK_UNKNOWN, '0, 1'b0, here, 16'd1, c);
      endcase
    end
  endtask

  // Works out the tokens that one accepted input beat gives.
  task automatic lex_byte(input in_t b);
    logic [7:0]  c;
    logic [15:0] here;
    logic [34:0] v;
    logic        taken;
    kind_t       kind;
    c     = b.ch;
    here  = lex_pos;
    taken = 1'b0;
    lex_n = 0;
    if (b.op || c == 8'd0) begin
      close_token();
      put_tok(TOK_EOF, '0, 1'b0, here, 16'd0, 8'd0);
      lex_clear();
    end else begin
      case (lex_mode)
        MODE_NUM: begin
          if (digit_ch(c)) begin
            v = 35'(lex_acc) * 35'd10 + 35'(c - 8'd48);
            if (v > 35'(NUM_MAX)) begin
              v = 35'(NUM_MAX);
              lex_sat = 1'b1;
            end
            lex_acc = v[30:0];
            if (lex_len != 16'hFFFF) lex_len++;
            taken = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (letter_ch(c) || digit_ch(c)) begin
            if (lex_len < KEYWORD_CHARS) lex_kw = {lex_kw[KW_BITS-9:0], c};
            if (lex_len != 16'hFFFF) lex_len++;
            taken = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (c == "/") begin
            lex_mode = MODE_COMMENT;
            taken = 1'b1;
          end
        end
        MODE_EQ, MODE_BANG, MODE_LT, MODE_GT: begin
          if (c == "=") begin
            case (lex_mode)
              MODE_EQ:   kind = TOK_EQ;
              MODE_BANG: kind = TOK_NE;
              MODE_LT:   kind = TOK_LE;
              default:   kind = TOK_GE;
            endcase
            put_tok(kind, '0, 1'b0, lex_start, 16'd2, 8'd0);
            lex_mode = MODE_IDLE;
            taken = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (c == CH_NEWLINE) lex_mode = MODE_IDLE;
          taken = 1'b1;
        end
        default: ;
      endcase
      if (!taken) begin
        close_token();
        open_token(c, here);
      end
      lex_pos = here + 16'd1;
    end
    for (int k = 0; k < lex_n; k++) lex_out[k].last_of_run = (k == lex_n - 1);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic add_row(input row_t r);
    feed.insert(feed.size(), r);
  endtask

  task automatic add_due(input out_t t);
    tokens_due.insert(tokens_due.size(), t);
  endtask

  task automatic put(input logic op, input logic [7:0] c);
    add_row('{op, c, 1'b0, '0});
    fed++;
  endtask

  function automatic logic [7:0] name_char(input logic first);
    int r;
    r = first ? $urandom_range(52) : $urandom_range(62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  // Mostly well-formed source with random content, some noise and early ends.
  task automatic gen_piece();
    string kws [5];
    string syms;
    string ops;
    int    pick;
    int    n;
    kws  = '{"if", "else", "for", "while", "return"};
    syms = "(){};,+-*%";
    ops  = "=!<>/";
    pick = $urandom_range(99);
    if (pick < 22) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      put(1'b0, name_char(1'b1));
      for (int k = 1; k < n; k++) put(1'b0, name_char(1'b0));
    end else if (pick < 30) begin
      n = $urandom_range(4);
      for (int k = 0; k < kws[n].len(); k++) put(1'b0, kws[n][k]);
      if ($urandom_range(3) == 0) put(1'b0, name_char(1'b0));
    end else if (pick < 44) begin
      n = ($urandom_range(5) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
      for (int k = 0; k < n; k++) put(1'b0, 8'("0" + $urandom_range(9)));
    end else if (pick < 56) begin
      put(1'b0, syms[$urandom_range(syms.len() - 1)]);
    end else if (pick < 66) begin
      put(1'b0, ops[$urandom_range(ops.len() - 1)]);
      if ($urandom_range(1)) put(1'b0, "=");
    end else if (pick < 76) begin
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++) begin
        pick = $urandom_range(5);
        put(1'b0, pick == 0 ? " " : 8'(8 + pick));
      end
    end else if (pick < 82) begin
      put(1'b0, "/");
      put(1'b0, "/");
      n = $urandom_range(6);
      for (int k = 0; k < n; k++) put(1'b0, 8'($urandom_range(32, 126)));
      if ($urandom_range(4) != 0) put(1'b0, CH_NEWLINE);
    end else if (pick < 94) begin
      put(1'b0, 8'($urandom_range(255)));
    end else begin
      put(1'b1, 8'($urandom_range(255)));
    end
    if ($urandom_range(1)) put(1'b0, " ");
  endtask

  // Sender: the head of the feed is the beat on offer until it is taken.
  always @(posedge clk) begin : sender
    row_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        lex_byte(in_data);
        r = feed.pop_front();
        if (r.typed) add_due(r.want);
        else for (int k = 0; k < lex_n; k++) add_due(lex_out[k]);
      end
      if (!in_valid || in_ready) begin
        if (feed.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          in_data  <= '{feed[0].op, feed[0].ch};
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    out_t w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (tokens_due.size() == 0) begin
          report("unexpected token kind", out_data.token_kind, -1);
        end else begin
          w = tokens_due.pop_front();
          if (out_data.token_kind != w.token_kind)
            report("token_kind", out_data.token_kind, w.token_kind);
          if (out_data.number_value != w.number_value)
            report("number_value", out_data.number_value, w.number_value);
          if (out_data.number_overflow != w.number_overflow)
            report("number_overflow", out_data.number_overflow, w.number_overflow);
          if (out_data.token_start != w.token_start)
            report("token_start", out_data.token_start, w.token_start);
          if (out_data.token_length != w.token_length)
            report("token_length", out_data.token_length, w.token_length);
          if (out_data.unknown_byte != w.unknown_byte)
            report("unknown_byte", out_data.unknown_byte, w.unknown_byte);
          if (out_data.last_of_run != w.last_of_run)
            report("last_of_run", out_data.last_of_run, w.last_of_run);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (feed.size() == 0 && tokens_due.size() == 0))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    script = '{
      '{1'b0, 8'hFF, 1'b1, '{TOK_UNKNOWN, 31'd0, 1'b0, 16'd0, 16'd1, 8'hFF, 1'b1}},
      '{1'b0, 8'h01, 1'b1, '{TOK_UNKNOWN, 31'd0, 1'b0, 16'd1, 16'd1, 8'h01, 1'b1}},
      '{1'b0, "!",   1'b0, '0},
      '{1'b0, "!",   1'b1, '{TOK_UNKNOWN, 31'd0, 1'b0, 16'd2, 16'd1, "!", 1'b1}},
      '{1'b0, "=",   1'b1, '{TOK_NE, 31'd0, 1'b0, 16'd3, 16'd2, 8'd0, 1'b1}},
      '{1'b0, "/",   1'b0, '0},
      '{1'b0, "/",   1'b0, '0},
      '{1'b0, "x",   1'b0, '0},
      // The source ends inside a comment: only the end-of-file token comes out.
      '{1'b1, 8'h55, 1'b1, '{TOK_EOF, 31'd0, 1'b0, 16'd8, 16'd0, 8'd0, 1'b1}},
      '{1'b0, "w",   1'b0, '0},
      '{1'b0, "h",   1'b0, '0},
      '{1'b0, "i",   1'b0, '0},
      '{1'b0, "l",   1'b0, '0},
      '{1'b0, "e",   1'b0, '0},
      '{1'b0, "(",   1'b0, '0},
      '{1'b0, "7",   1'b0, '0},
      '{1'b0, "<",   1'b0, '0},
      '{1'b0, "=",   1'b0, '0},
      '{1'b0, ">",   1'b0, '0},
      '{1'b0, ">",   1'b0, '0},
      // A zero byte closes the pending operator and ends the source.
      '{1'b0, 8'h00, 1'b0, '0},
      '{1'b0, "i",   1'b0, '0},
      '{1'b0, "f",   1'b0, '0},
      '{1'b0, "%",   1'b0, '0},
      '{1'b1, 8'hFF, 1'b1, '{TOK_EOF, 31'd0, 1'b0, 16'd3, 16'd0, 8'd0, 1'b1}}
    };
    lex_clear();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      @(negedge clk);
      send_idle = (ph == 0) ? 34 : (ph == 1) ? 55 : 0;
      recv_idle = (ph == 0) ? 55 : (ph == 1) ? 34 : 0;
      if (ph == 0) foreach (script[k]) add_row(script[k]);
      fed = 0;
      while (fed < PHASE_ITEMS) gen_piece();
      while (feed.size() != 0 || tokens_due.size() != 0) @(negedge clk);
    end
    repeat (16) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/ctok_pkg.sv
rtl/ctok_scan.sv
rtl/c_like_tokenizer_unit.sv
rtl/ctok_checker.sv
bench/c_like_tokenizer_unit_test.sv
